// File: design/assert_macros.svh
// Concurrent assertion helpers, clocked on clk and quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// expr must never be true at a clock edge outside reset
`define ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, expr)

`endif

`endif

// File: design/spq_pkg.sv
package spq_pkg;

    // fixed field widths of the channels
    localparam int unsigned OP_W     = 1;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned WEIGHT_W = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_JOIN  = 1'b0;
    localparam logic [OP_W-1:0] OP_LEAVE = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // shift command broadcast to every cell
    typedef struct packed {
        logic do_join;
        logic do_leave;
    } cell_ctrl_t;

endpackage

// File: design/spq_if.sv
// request channel: one join or leave per transfer
interface spq_req_if;
    logic                               valid;
    logic                               ready;
    logic [spq_pkg::OP_W-1:0]           op;
    logic [spq_pkg::VALUE_W-1:0]        item_value;
    logic signed [spq_pkg::WEIGHT_W-1:0] weight;

    modport source (output valid, op, item_value, weight, input ready);
    modport sink   (input valid, op, item_value, weight, output ready);
endinterface

// response channel: one result per request
interface spq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [spq_pkg::VALUE_W-1:0]   out_value;
    logic [spq_pkg::STATUS_W-1:0]  status;
    logic                          is_empty;
    logic [spq_pkg::COUNT_W-1:0]   count;

    modport source (output valid, out_value, status, is_empty, count, input ready);
    modport sink   (input valid, out_value, status, is_empty, count, output ready);
endinterface

// File: design/spq_cell.sv
// One slot of the sorted row. Compares the joining weight against its own,
// then holds, loads from the left neighbor, loads the new entry, or loads
// from the right neighbor on a leave.
module spq_cell #(
    parameter int unsigned VW = 32,
    parameter int unsigned WW = 16
) (
    input  logic                 clk,
    input  spq_pkg::cell_ctrl_t  ctrl,
    input  logic                 occupied,
    input  logic [VW-1:0]        new_value,
    input  logic signed [WW-1:0] new_weight,
    input  logic [VW-1:0]        left_value,
    input  logic signed [WW-1:0] left_weight,
    input  logic                 left_ins,
    input  logic [VW-1:0]        right_value,
    input  logic signed [WW-1:0] right_weight,
    output logic [VW-1:0]        value,
    output logic signed [WW-1:0] weight,
    output logic                 ins
);

    logic [VW-1:0]        value_reg;
    logic [VW-1:0]        value_next;
    logic signed [WW-1:0] weight_reg;
    logic signed [WW-1:0] weight_next;

    // strict compare keeps equal weights in arrival order
    assign ins = !occupied || (new_weight > weight_reg);

    always_comb
    begin
        value_next  = value_reg;
        weight_next = weight_reg;
        if (ctrl.do_join && ins)
        begin
            if (left_ins)
            begin
                value_next  = left_value;
                weight_next = left_weight;
            end
            else
            begin
                value_next  = new_value;
                weight_next = new_weight;
            end
        end
        else if (ctrl.do_leave)
        begin
            value_next  = right_value;
            weight_next = right_weight;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        weight_reg <= weight_next;
    end

    assign value  = value_reg;
    assign weight = weight_reg;

endmodule

// File: design/stable_priority_queue.sv
// Stable bounded priority queue of up to CAPACITY entries held in a row of
// cells, head in cell 0, sorted by signed weight with the highest first and
// equal weights in arrival order. Every request transfer (join or leave) is
// handled at once: all cells compare the joining weight in parallel and
// the whole row shifts right to open a slot, or left to drop the head, at the
// same clock edge. The result appears in the output register the cycle after
// the request transfer, and a new request is accepted in every cycle in which
// that register is empty or being drained, so throughput is one request per
// cycle. A join on a full queue is dropped with status 2, a leave on an empty
// queue returns status 1 and value zero; count is reported modulo 32.
// Cell contents are not reset; only the entry count and the output valid are.
`include "assert_macros.svh"

module stable_priority_queue #(
    parameter int unsigned CAPACITY     = 16,
    parameter int unsigned VALUE_WIDTH  = 32,
    parameter int unsigned WEIGHT_WIDTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    // entry count
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // output register
    logic                          ov_reg;
    logic                          ov_next;
    logic [spq_pkg::VALUE_W-1:0]   rsp_value_reg;
    logic [spq_pkg::VALUE_W-1:0]   rsp_value_next;
    logic [spq_pkg::STATUS_W-1:0]  rsp_status_reg;
    logic [spq_pkg::STATUS_W-1:0]  rsp_status_next;
    logic [CNT_W-1:0]              rsp_cnt_reg;

    logic                     accept;
    logic                     is_full;
    logic                     is_empty_q;
    spq_pkg::cell_ctrl_t      ctrl;
    logic [VALUE_WIDTH-1:0]   join_value;
    logic signed [WEIGHT_WIDTH-1:0] join_weight;

    // cell row taps
    logic [VALUE_WIDTH-1:0]         cell_value  [CAPACITY];
    logic signed [WEIGHT_WIDTH-1:0] cell_weight [CAPACITY];
    logic [CAPACITY-1:0]            cell_ins;
    logic [CAPACITY-1:0]            cell_occ;

    // skid-free handshake: ready while the result slot is free or draining
    assign req.ready = !ov_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign is_full    = (cnt_reg == CNT_FULL);
    assign is_empty_q = (cnt_reg == '0);

    assign join_value  = VALUE_WIDTH'(req.item_value);
    assign join_weight = WEIGHT_WIDTH'(req.weight);

    assign ctrl.do_join  = accept && (req.op == spq_pkg::OP_JOIN) && !is_full;
    assign ctrl.do_leave = accept && (req.op == spq_pkg::OP_LEAVE) && !is_empty_q;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0]         lv;
        logic signed [WEIGHT_WIDTH-1:0] lw;
        logic                           li;
        logic [VALUE_WIDTH-1:0]         rv;
        logic signed [WEIGHT_WIDTH-1:0] rw;

        if (i == 0)
        begin : g_head
            assign lv = join_value;
            assign lw = join_weight;
            assign li = 1'b0;
        end
        else
        begin : g_left
            assign lv = cell_value[i-1];
            assign lw = cell_weight[i-1];
            assign li = cell_ins[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            // last slot is vacated by a leave; its content no longer counts
            assign rv = cell_value[i];
            assign rw = cell_weight[i];
        end
        else
        begin : g_right
            assign rv = cell_value[i+1];
            assign rw = cell_weight[i+1];
        end

        assign cell_occ[i] = (cnt_reg > CNT_W'(i));

        spq_cell #(
            .VW (VALUE_WIDTH),
            .WW (WEIGHT_WIDTH)
        ) u_cell (
            .clk          (clk),
            .ctrl         (ctrl),
            .occupied     (cell_occ[i]),
            .new_value    (join_value),
            .new_weight   (join_weight),
            .left_value   (lv),
            .left_weight  (lw),
            .left_ins     (li),
            .right_value  (rv),
            .right_weight (rw),
            .value        (cell_value[i]),
            .weight       (cell_weight[i]),
            .ins          (cell_ins[i])
        );
    end

    always_comb
    begin
        cnt_next        = cnt_reg;
        rsp_value_next  = '0;
        rsp_status_next = spq_pkg::ST_OK;
        ov_next         = ov_reg && !rsp.ready;
        if (accept)
        begin
            ov_next = 1'b1;
            if (req.op == spq_pkg::OP_LEAVE)
            begin
                if (is_empty_q)
                begin
                    rsp_status_next = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    rsp_value_next = spq_pkg::VALUE_W'(cell_value[0]);
                    cnt_next       = cnt_reg - 1'b1;
                end
            end
            else
            begin
                if (is_full)
                begin
                    rsp_status_next = spq_pkg::ST_FULL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ov_reg  <= ov_next;
        end
    end

    // result payload, loaded on each request transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_value_reg  <= rsp_value_next;
            rsp_status_reg <= rsp_status_next;
            rsp_cnt_reg    <= cnt_next;
        end
    end

    assign rsp.valid     = ov_reg;
    assign rsp.out_value = rsp_value_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.is_empty  = (rsp_cnt_reg == '0);
    assign rsp.count     = spq_pkg::COUNT_W'(rsp_cnt_reg);

    `ASSERT_CLK(a_cnt_bound, cnt_reg <= CNT_FULL)
    `ASSERT_CLK(a_join_grows, ctrl.do_join |=> cnt_reg == CNT_W'($past(cnt_reg) + 1'b1))
    `ASSERT_CLK(a_leave_head, ctrl.do_leave |=> rsp_value_reg == spq_pkg::VALUE_W'($past(cell_value[0])))
    `ASSERT_NEVER(a_full_flag, ov_reg && rsp_status_reg == spq_pkg::ST_FULL && rsp_cnt_reg != CNT_FULL)
    `ASSERT_NEVER(a_head_order, cnt_reg >= CNT_W'(2) && cell_weight[0] < cell_weight[1])

endmodule

// File: verif/testbench.sv
module testbench;

    localparam int unsigned DEPTH        = 16;
    localparam int unsigned RANDOM_ITEMS = 400;
    localparam int unsigned BLOCK_ITEMS  = 40;

    // one result as it appears on the response channel
    typedef struct packed {
        logic [spq_pkg::VALUE_W-1:0]  out_value;
        logic [spq_pkg::STATUS_W-1:0] status;
        logic                         is_empty;
        logic [spq_pkg::COUNT_W-1:0]  count;
    } queue_result_t;

    // directed stimulus row; want is only meaningful when typed is set
    typedef struct packed {
        logic [spq_pkg::OP_W-1:0]            op;
        logic [spq_pkg::VALUE_W-1:0]         value;
        logic signed [spq_pkg::WEIGHT_W-1:0] weight;
        logic                                typed;
        queue_result_t                       want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    stable_priority_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // 12 time unit period
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // predictor state: sorted copy of the queue, head at index 0
    logic [spq_pkg::VALUE_W-1:0]         held_values  [DEPTH];
    logic signed [spq_pkg::WEIGHT_W-1:0] held_weights [DEPTH];
    int unsigned                         held_count;

    queue_result_t pending_results [$];
    int unsigned   mismatches;
    bit            calm;    // suppresses idling on both channels

    stim_row_t directed_rows [24];

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Works out the result of one join or leave and updates the held state.
    function automatic queue_result_t predict_queue_op(
        input logic [spq_pkg::OP_W-1:0]            op,
        input logic [spq_pkg::VALUE_W-1:0]         value,
        input logic signed [spq_pkg::WEIGHT_W-1:0] weight
    );
        queue_result_t res;
        int unsigned   slot;
        res = '0;
        res.status = spq_pkg::ST_OK;
        if (op == spq_pkg::OP_LEAVE) begin
            if (held_count == 0) begin
                res.status = spq_pkg::ST_EMPTY;
            end
            else begin
                res.out_value = held_values[0];
                for (int unsigned i = 1; i < held_count; i++) begin
                    held_values[i-1]  = held_values[i];
                    held_weights[i-1] = held_weights[i];
                end
                held_count--;
            end
        end
        else if (held_count >= DEPTH) begin
            res.status = spq_pkg::ST_FULL;
        end
        else begin
            // new entry goes behind everything of greater or equal weight
            slot = held_count;
            for (int unsigned i = 0; i < held_count; i++) begin
                if (weight > held_weights[i]) begin
                    slot = i;
                    break;
                end
            end
            for (int unsigned i = held_count; i > slot; i--) begin
                held_values[i]  = held_values[i-1];
                held_weights[i] = held_weights[i-1];
            end
            held_values[slot]  = value;
            held_weights[slot] = weight;
            held_count++;
        end
        res.is_empty = (held_count == 0);
        res.count    = spq_pkg::COUNT_W'(held_count);
        return res;
    endfunction

    // Presents one request, holds it until the transfer, then files the
    // expected result. Valid stays high into the next item unless it idles.
    task automatic send_item(
        input logic [spq_pkg::OP_W-1:0]            op,
        input logic [spq_pkg::VALUE_W-1:0]         value,
        input logic signed [spq_pkg::WEIGHT_W-1:0] weight,
        input logic                                typed,
        input queue_result_t                       want
    );
        queue_result_t predicted;
        while (!calm && $urandom_range(99) < 25) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.op         <= op;
        req_ch.item_value <= value;
        req_ch.weight     <= weight;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = predict_queue_op(op, value, weight);
        if (typed && predicted != want)
            report_mismatch("directed row disagrees with predicted result");
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Response side: checks each transfer against the oldest expectation,
    // then picks ready for the next cycle.
    always @(posedge clk) begin
        queue_result_t got;
        queue_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.out_value = rsp_ch.out_value;
            got.status    = rsp_ch.status;
            got.is_empty  = rsp_ch.is_empty;
            got.count     = rsp_ch.count;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: %p", got));
            end
            else begin
                want = pending_results.pop_front();
                if (got.out_value !== want.out_value)
                    report_mismatch($sformatf("out_value %h, expected %h",
                                              got.out_value, want.out_value));
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              got.status, want.status));
                if (got.is_empty !== want.is_empty)
                    report_mismatch($sformatf("is_empty %b, expected %b",
                                              got.is_empty, want.is_empty));
                if (got.count !== want.count)
                    report_mismatch($sformatf("count %0d, expected %0d",
                                              got.count, want.count));
            end
        end
        rsp_ch.ready <= calm || ($urandom_range(99) >= 25);
    end

    // Random weight: mostly a narrow band so ties are common, plus full range
    // and the two extremes.
    function automatic logic signed [spq_pkg::WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(3))
            0:       return spq_pkg::WEIGHT_W'(int'($urandom_range(4)) - 2);
            1:       return spq_pkg::WEIGHT_W'($urandom);
            2:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return spq_pkg::WEIGHT_W'(int'($urandom_range(15)) - 8);
        endcase
    endfunction

    function automatic logic [spq_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int unsigned              join_pct;
        logic [spq_pkg::OP_W-1:0] op;
        queue_result_t            no_want;

        no_want = '0;
        // leave on empty, first join, join on full and the first leave
        // after the fill can be read off directly; the rest go through the
        // predictor. Ties at zero, at the top and at the bottom are mixed in.
        directed_rows = '{
            '{spq_pkg::OP_LEAVE, 32'h1234_5678, 16'sh0005, 1'b1,
              '{32'h0, spq_pkg::ST_EMPTY, 1'b1, 5'd0}},
            '{spq_pkg::OP_JOIN,  32'h0000_0000, 16'sh0000, 1'b1,
              '{32'h0, spq_pkg::ST_OK, 1'b0, 5'd1}},
            '{spq_pkg::OP_JOIN,  32'hffff_ffff, 16'sh7fff, 1'b0, '0},
            '{spq_pkg::OP_JOIN,  32'h0000_0001, 16'sh8000, 1'b0, '0},
            '{spq_pkg::OP_JOIN,  32'h0000_0002, 16'sh0000, 1'b0, '0},
            '{spq_pkg::OP_JOIN,  32'h0000_0003, 16'sh0000, 1'b0, '0},
            '{spq_pkg::OP_JOIN,  32'h0000_0004, 16'sh7fff, 1'b0, '0},
            '{spq_pkg::OP_JOIN,  32'h0000_0005, 16'sh8000, 1'b0, '0},
            '{spq_pkg::OP_JOIN,  32'h0000_0006, 16'shffff, 1'b0, '0},
            '{spq_pkg::OP_JOIN,  32'h0000_0007, 16'sh0001, 1'b0, '0},
            '{spq_pkg::OP_JOIN,  32'ha5a5_a5a5, 16'sh0064, 1'b0, '0},
            '{spq_pkg::OP_JOIN,  32'h5a5a_5a5a, 16'shff9c, 1'b0, '0},
            '{spq_pkg::OP_JOIN,  32'h8000_0000, 16'sh4000, 1'b0, '0},
            '{spq_pkg::OP_JOIN,  32'h7fff_ffff, 16'shbfff, 1'b0, '0},
            '{spq_pkg::OP_JOIN,  32'h0000_0008, 16'sh0000, 1'b0, '0},
            '{spq_pkg::OP_JOIN,  32'h0000_0009, 16'sh7fff, 1'b0, '0},
            '{spq_pkg::OP_JOIN,  32'h0000_000a, 16'sh8000, 1'b0, '0},
            '{spq_pkg::OP_JOIN,  32'hdead_beef, 16'sh0005, 1'b1,
              '{32'h0, spq_pkg::ST_FULL, 1'b0, 5'd16}},
            '{spq_pkg::OP_LEAVE, 32'hffff_ffff, 16'sh7fff, 1'b1,
              '{32'hffff_ffff, spq_pkg::ST_OK, 1'b0, 5'd15}},
            '{spq_pkg::OP_LEAVE, 32'h0000_0000, 16'sh8000, 1'b0, '0},
            '{spq_pkg::OP_LEAVE, 32'h5555_5555, 16'sh0000, 1'b0, '0},
            '{spq_pkg::OP_LEAVE, 32'haaaa_aaaa, 16'shffff, 1'b0, '0},
            '{spq_pkg::OP_JOIN,  32'h0000_00ff, 16'sh7fff, 1'b0, '0},
            '{spq_pkg::OP_LEAVE, 32'h0000_0000, 16'sh0000, 1'b0, '0}
        };

        // all inputs known from time zero
        rst_n             = 1'b0;
        calm              = 1'b0;
        mismatches        = 0;
        held_count        = 0;
        req_ch.valid      = 1'b0;
        req_ch.op         = spq_pkg::OP_JOIN;
        req_ch.item_value = '0;
        req_ch.weight     = '0;
        rsp_ch.ready      = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].value,
                      directed_rows[i].weight, directed_rows[i].typed,
                      directed_rows[i].want);

        // Random part in blocks that lean toward filling, balance, or
        // draining, so the queue swings between full and empty repeatedly.
        // Two middle blocks run with no idling on either channel.
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            case ((n / BLOCK_ITEMS) % 3)
                0:       join_pct = 85;
                1:       join_pct = 50;
                default: join_pct = 15;
            endcase
            calm = (n / BLOCK_ITEMS == 4) || (n / BLOCK_ITEMS == 5);
            op = ($urandom_range(99) < join_pct) ? spq_pkg::OP_JOIN : spq_pkg::OP_LEAVE;
            send_item(op, pick_value(), pick_weight(), 1'b0, no_want);
        end
        calm = 1'b0;
        req_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        // keep clocking to catch any stray result
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2400000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
